// ===== hw/rtl/qat_pkg.sv =====
package qat_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned ModeW = 2;

  // output queue entries: room for one double result plus the word in front
  localparam int unsigned OutDepth = 3;

  // parse modes
  localparam logic [ModeW-1:0] ModeBetween = 2'd0;
  localparam logic [ModeW-1:0] ModeBare    = 2'd1;
  localparam logic [ModeW-1:0] ModeQuoted  = 2'd2;

  // event kinds
  localparam logic [KindW-1:0] EvByte      = 2'd0;
  localparam logic [KindW-1:0] EvEndToken  = 2'd1;
  localparam logic [KindW-1:0] EvEndRecord = 2'd2;

  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChDquote = 8'h22;
  localparam logic [CharW-1:0] ChSquote = 8'h27;
  localparam logic [CharW-1:0] ChNul    = 8'h00;

  // register indexes
  localparam logic RegTerminator = 1'b0;
  localparam logic RegSeparator  = 1'b1;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CharW-1:0] token_byte;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [CharW-1:0] terminator;
    logic [CharW-1:0] separator;
  } cfg_t;

  // words handed from the parser to the output queue
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// ===== hw/rtl/quote_aware_tokenizer.sv =====
// channel   | dir | handshake                         | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready     | tdata[7:0] in_char
// m_axis    | out | m_axis_tvalid / m_axis_tready     | tdata[7:0] token_byte,
//           |     |                                   | tuser[1:0] event_kind, tlast last_of_run
// apb       | in  | psel & penable & pwrite & pready  | 0x0 terminator_char, 0x4 separator_char
//
// One character is taken per cycle while s_axis_tready is high; each gives zero, one or
// two words, which leave through a three-entry output queue one word per cycle while
// m_axis_tready is high. s_axis_tready is high while the queue holds at most one word,
// so a double result (end of token and end of record) stalls input even at steady drain.
// Reset clears the parse state, the queue and both registers; no clearing pass.
module quote_aware_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] token_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  qat_pkg::cfg_t    cfg_q;
  qat_pkg::push_t   push;
  qat_pkg::result_t head;
  logic             accept, pop, room, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        qat_pkg::RegTerminator: cfg_q.terminator <= pwdata[7:0];
        qat_pkg::RegSeparator:  cfg_q.separator  <= pwdata[7:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      qat_pkg::RegTerminator: prdata = {24'd0, cfg_q.terminator};
      qat_pkg::RegSeparator:  prdata = {24'd0, cfg_q.separator};
      default:                prdata = 32'd0;
    endcase
  end

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;
  assign pop           = m_axis_tvalid && m_axis_tready;

  qat_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_char_i (s_axis_tdata),
    .cfg_i     (cfg_q),
    .push_o    (push)
  );

  qat_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .head_o  (head)
  );

  assign m_axis_tdata = head.token_byte;
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

// ===== hw/rtl/qat_parse.sv =====
module qat_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [qat_pkg::CharW-1:0]  in_char_i,
  input  qat_pkg::cfg_t              cfg_i,
  output qat_pkg::push_t             push_o
);

  logic [qat_pkg::ModeW-1:0] mode_q, mode_d;
  logic                      single_q, single_d;
  logic                      nonempty_q, nonempty_d;

  logic                      is_gap, is_end;
  logic [qat_pkg::CharW-1:0] close_ch;
  qat_pkg::push_t            push;

  assign is_gap = (in_char_i == qat_pkg::ChSpace) || (in_char_i == qat_pkg::ChTab) ||
                  ((cfg_i.separator != qat_pkg::ChNul) && (in_char_i == cfg_i.separator));
  assign is_end = (in_char_i == qat_pkg::ChNul) || (in_char_i == cfg_i.terminator);
  assign close_ch = single_q ? qat_pkg::ChSquote : qat_pkg::ChDquote;

  always_comb begin
    mode_d     = mode_q;
    single_d   = single_q;
    nonempty_d = nonempty_q;
    push       = '0;
    case (mode_q)
      qat_pkg::ModeBare: begin
        if (is_end) begin
          push.count     = 2'd2;
          push.res0.kind = qat_pkg::EvEndToken;
          push.res1.kind = qat_pkg::EvEndRecord;
          push.res1.last = 1'b1;
          mode_d         = qat_pkg::ModeBetween;
        end else if (is_gap) begin
          push.count     = 2'd1;
          push.res0.kind = qat_pkg::EvEndToken;
          push.res0.last = 1'b1;
          mode_d         = qat_pkg::ModeBetween;
        end else begin
          push.count           = 2'd1;
          push.res0.kind       = qat_pkg::EvByte;
          push.res0.token_byte = in_char_i;
          push.res0.last       = 1'b1;
        end
      end
      qat_pkg::ModeQuoted: begin
        if (is_end) begin
          if (nonempty_q) begin
            push.count     = 2'd2;
            push.res0.kind = qat_pkg::EvEndToken;
            push.res1.kind = qat_pkg::EvEndRecord;
            push.res1.last = 1'b1;
          end else begin
            push.count     = 2'd1;
            push.res0.kind = qat_pkg::EvEndRecord;
            push.res0.last = 1'b1;
          end
          mode_d     = qat_pkg::ModeBetween;
          nonempty_d = 1'b0;
        end else if (in_char_i == close_ch) begin
          if (nonempty_q) begin
            push.count     = 2'd1;
            push.res0.kind = qat_pkg::EvEndToken;
            push.res0.last = 1'b1;
          end
          mode_d     = qat_pkg::ModeBetween;
          nonempty_d = 1'b0;
        end else begin
          push.count           = 2'd1;
          push.res0.kind       = qat_pkg::EvByte;
          push.res0.token_byte = in_char_i;
          push.res0.last       = 1'b1;
          nonempty_d           = 1'b1;
        end
      end
      default: begin
        // between tokens; the unused code lands here too
        mode_d = qat_pkg::ModeBetween;
        if (is_gap) begin
          mode_d = qat_pkg::ModeBetween;
        end else if (is_end) begin
          push.count     = 2'd1;
          push.res0.kind = qat_pkg::EvEndRecord;
          push.res0.last = 1'b1;
        end else if ((in_char_i == qat_pkg::ChDquote) || (in_char_i == qat_pkg::ChSquote)) begin
          mode_d     = qat_pkg::ModeQuoted;
          single_d   = (in_char_i == qat_pkg::ChSquote);
          nonempty_d = 1'b0;
        end else begin
          push.count           = 2'd1;
          push.res0.kind       = qat_pkg::EvByte;
          push.res0.token_byte = in_char_i;
          push.res0.last       = 1'b1;
          mode_d               = qat_pkg::ModeBare;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= qat_pkg::ModeBetween;
      single_q   <= 1'b0;
      nonempty_q <= 1'b0;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      single_q   <= single_d;
      nonempty_q <= nonempty_d;
    end
  end

  assign push_o.count = accept_i ? push.count : 2'd0;
  assign push_o.res0  = push.res0;
  assign push_o.res1  = push.res1;

  a_two_ends_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count == 2'd2) |-> (push.res1.kind == qat_pkg::EvEndRecord) && push.res1.last &&
                             (push.res0.kind == qat_pkg::EvEndToken) && !push.res0.last)
    else $error("double result is not end of token then end of record");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count == 2'd1) |-> push.res0.last)
    else $error("single result lacks last flag");

  a_nonempty_quoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != qat_pkg::ModeQuoted) |-> !nonempty_q)
    else $error("token content flag set outside a quoted token");

endmodule

// ===== hw/rtl/qat_outq.sv =====
module qat_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qat_pkg::push_t   push_i,
  input  logic             pop_i,
  output logic             room_o,
  output logic             valid_o,
  output qat_pkg::result_t head_o
);

  qat_pkg::result_t slot_q [qat_pkg::OutDepth];
  qat_pkg::result_t slot_d [qat_pkg::OutDepth];
  qat_pkg::result_t shifted [qat_pkg::OutDepth];
  logic [1:0]       count_q, count_d, base;

  assign valid_o = (count_q != 2'd0);
  // room for a full double result
  assign room_o  = (count_q <= 2'd1);
  assign head_o  = slot_q[0];

  assign base    = count_q - {1'b0, pop_i};
  assign count_d = base + push_i.count;

  always_comb begin
    for (int i = 0; i < qat_pkg::OutDepth; i++) begin
      shifted[i] = (pop_i && (i < qat_pkg::OutDepth - 1)) ?
                   slot_q[(i + 1) % qat_pkg::OutDepth] : slot_q[i];
      if ((push_i.count != 2'd0) && (base == 2'(i))) begin
        slot_d[i] = push_i.res0;
      end else if ((push_i.count == 2'd2) && ((base + 2'd1) == 2'(i))) begin
        slot_d[i] = push_i.res1;
      end else begin
        slot_d[i] = shifted[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < qat_pkg::OutDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) - {1'b0, $past(pop_i)} + $past(push_i.count)))
    else $error("queue count lost track of pushes and pops");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (count_q <= 2'd1))
    else $error("push into a queue without room");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && (count_q == 2'd1) && (push_i.count == 2'd0)) |=> !valid_o)
    else $error("queue still valid after last word taken");

endmodule
